@@ src/slpb_pkg.sv @@
// ----------------------------------------------------------------------------
// slpb_pkg
// Shared widths, types and coefficient constants of the selectable low-pass
// biquad.
// ----------------------------------------------------------------------------
package slpb_pkg;

    // Sample and fixed-point formats.
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 22;
    localparam int COEF_WIDTH     = COEF_FRAC_BITS + 2;
    localparam int HIST_FRAC_BITS = 8;
    localparam int HIST_WIDTH     = SAMPLE_WIDTH + HIST_FRAC_BITS;
    localparam int SUM_WIDTH      = SAMPLE_WIDTH + 3;
    localparam int SEL_WIDTH      = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [HIST_WIDTH-1:0]   hist_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic        [SEL_WIDTH-1:0]    select_t;

    // Cutoff select codes.
    localparam select_t SEL_BYPASS = 3'd0;
    localparam select_t SEL_CUT30  = 3'd1;
    localparam select_t SEL_CUT40  = 3'd2;
    localparam select_t SEL_CUT60  = 3'd3;
    localparam select_t SEL_CUT80  = 3'd4;
    localparam select_t SEL_CUT100 = 3'd5;
    localparam select_t SEL_CUT150 = 3'd6;

    // One coefficient set; active is low in bypass.
    typedef struct packed {
        logic  active;
        coef_t b;
        coef_t a0;
        coef_t a1;
    } coef_set_t;

    // Coefficients are given in units of 1e-4.
    localparam longint DECIMAL_SCALE = 10000;
    localparam longint DECIMAL_ROUND = 5000;

    // Converts a four-decimal constant to Q2.22, rounding half away from zero.
    function automatic coef_t scale_coef(input int decimal);
        longint mag;
        longint scaled;
        mag    = (decimal < 0) ? -longint'(decimal) : longint'(decimal);
        scaled = ((mag << COEF_FRAC_BITS) + DECIMAL_ROUND) / DECIMAL_SCALE;
        return (decimal < 0) ? COEF_WIDTH'(-scaled) : COEF_WIDTH'(scaled);
    endfunction

    localparam coef_t B_CUT30   = scale_coef(78);
    localparam coef_t A0_CUT30  = scale_coef(17347);
    localparam coef_t A1_CUT30  = scale_coef(-7660);
    localparam coef_t B_CUT40   = scale_coef(134);
    localparam coef_t A0_CUT40  = scale_coef(16457);
    localparam coef_t A1_CUT40  = scale_coef(-7009);
    localparam coef_t B_CUT60   = scale_coef(279);
    localparam coef_t A0_CUT60  = scale_coef(14755);
    localparam coef_t A1_CUT60  = scale_coef(-5869);
    localparam coef_t B_CUT80   = scale_coef(461);
    localparam coef_t A0_CUT80  = scale_coef(13073);
    localparam coef_t A1_CUT80  = scale_coef(-4918);
    localparam coef_t B_CUT100  = scale_coef(675);
    localparam coef_t A0_CUT100 = scale_coef(11430);
    localparam coef_t A1_CUT100 = scale_coef(-4128);
    localparam coef_t B_CUT150  = scale_coef(913);
    localparam coef_t A0_CUT150 = scale_coef(9824);
    localparam coef_t A1_CUT150 = scale_coef(-3477);

endpackage

@@ src/slpb_coef_rom.sv @@
// ----------------------------------------------------------------------------
// slpb_coef_rom
// Maps the cutoff select code to its coefficient set or to bypass.
// ----------------------------------------------------------------------------
module slpb_coef_rom (
    input  slpb_pkg::select_t   cutoff_select,
    output slpb_pkg::coef_set_t coefs
);
    import slpb_pkg::*;

    always_comb begin
        coefs = '{active: 1'b1, b: B_CUT30, a0: A0_CUT30, a1: A1_CUT30};
        case (cutoff_select)
            SEL_CUT30: begin
                coefs = '{active: 1'b1, b: B_CUT30, a0: A0_CUT30, a1: A1_CUT30};
            end
            SEL_CUT40: begin
                coefs = '{active: 1'b1, b: B_CUT40, a0: A0_CUT40, a1: A1_CUT40};
            end
            SEL_CUT60: begin
                coefs = '{active: 1'b1, b: B_CUT60, a0: A0_CUT60, a1: A1_CUT60};
            end
            SEL_CUT80: begin
                coefs = '{active: 1'b1, b: B_CUT80, a0: A0_CUT80, a1: A1_CUT80};
            end
            SEL_CUT100: begin
                coefs = '{active: 1'b1, b: B_CUT100, a0: A0_CUT100, a1: A1_CUT100};
            end
            SEL_CUT150: begin
                coefs = '{active: 1'b1, b: B_CUT150, a0: A0_CUT150, a1: A1_CUT150};
            end
            default: begin
                // Bypass and the unused code: coefficients are don't-care.
                coefs = '{active: 1'b0, b: '0, a0: '0, a1: '0};
            end
        endcase
    end

endmodule

@@ src/slpb_datapath.sv @@
// ----------------------------------------------------------------------------
// slpb_datapath
// One biquad step: three multiplies, an add tree, rounding and saturation.
// ----------------------------------------------------------------------------
module slpb_datapath (
    input  slpb_pkg::sample_t   x0,
    input  slpb_pkg::sample_t   x1,
    input  slpb_pkg::sample_t   x2,
    input  slpb_pkg::hist_t     y1,
    input  slpb_pkg::hist_t     y2,
    input  slpb_pkg::coef_set_t coefs,
    output slpb_pkg::hist_t     y_hist,
    output slpb_pkg::sample_t   y_sample
);
    import slpb_pkg::*;

    localparam int PROD_B_WIDTH = COEF_WIDTH + SUM_WIDTH;
    localparam int PROD_A_WIDTH = COEF_WIDTH + HIST_WIDTH;
    localparam int ACC_WIDTH    = PROD_B_WIDTH + HIST_FRAC_BITS + 2;
    localparam int Y_WIDTH      = ACC_WIDTH - COEF_FRAC_BITS;
    localparam int RND_WIDTH    = HIST_WIDTH + 1;

    localparam logic signed [ACC_WIDTH-1:0] ROUND_ACC =
        ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [RND_WIDTH-1:0] ROUND_OUT =
        RND_WIDTH'(1) << (HIST_FRAC_BITS - 1);
    localparam hist_t   HIST_MAX   = {1'b0, {(HIST_WIDTH-1){1'b1}}};
    localparam hist_t   HIST_MIN   = {1'b1, {(HIST_WIDTH-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SUM_WIDTH-1:0]    sx;
    logic signed [PROD_B_WIDTH-1:0] prod_b;
    logic signed [PROD_A_WIDTH-1:0] prod_a0;
    logic signed [PROD_A_WIDTH-1:0] prod_a1;
    logic signed [ACC_WIDTH-1:0]    acc;
    logic signed [Y_WIDTH-1:0]      y_wide;
    logic        [Y_WIDTH-HIST_WIDTH:0] y_upper;
    logic signed [RND_WIDTH-1:0]    y_round;
    logic signed [SAMPLE_WIDTH:0]   o_wide;

    assign sx = SUM_WIDTH'(x0) + (SUM_WIDTH'(x1) <<< 1) + SUM_WIDTH'(x2);

    assign prod_b  = PROD_B_WIDTH'(coefs.b)  * PROD_B_WIDTH'(sx);
    assign prod_a0 = PROD_A_WIDTH'(coefs.a0) * PROD_A_WIDTH'(y1);
    assign prod_a1 = PROD_A_WIDTH'(coefs.a1) * PROD_A_WIDTH'(y2);

    assign acc = (ACC_WIDTH'(prod_b) <<< HIST_FRAC_BITS) + ACC_WIDTH'(prod_a0)
               + ACC_WIDTH'(prod_a1) + ROUND_ACC;

    // Floor shift back to the history format, then saturate.
    assign y_wide  = Y_WIDTH'(acc >>> COEF_FRAC_BITS);
    assign y_upper = y_wide[Y_WIDTH-1:HIST_WIDTH-1];

    always_comb begin
        if ((&y_upper) || !(|y_upper)) begin
            y_hist = y_wide[HIST_WIDTH-1:0];
        end else if (y_wide[Y_WIDTH-1]) begin
            y_hist = HIST_MIN;
        end else begin
            y_hist = HIST_MAX;
        end
    end

    // Round the history value to an integer sample, then saturate again.
    assign y_round = RND_WIDTH'(y_hist) + ROUND_OUT;
    assign o_wide  = y_round[RND_WIDTH-1:HIST_FRAC_BITS];

    always_comb begin
        if (o_wide[SAMPLE_WIDTH] == o_wide[SAMPLE_WIDTH-1]) begin
            y_sample = o_wide[SAMPLE_WIDTH-1:0];
        end else if (o_wide[SAMPLE_WIDTH]) begin
            y_sample = SAMPLE_MIN;
        end else begin
            y_sample = SAMPLE_MAX;
        end
    end

endmodule

@@ src/selectable_lowpass_biquad.sv @@
// ----------------------------------------------------------------------------
// selectable_lowpass_biquad
// Second-order low-pass IIR filter with six selectable cutoff settings and a
// bypass mode, one output sample per input sample.
// ----------------------------------------------------------------------------
// The block accepts one sample per clock cycle as long as the result side
// keeps taking transfers; each result passes through the input register and
// then the result register. A sample is captured in the input register; when
// it moves on, the full biquad step (three multiplies in parallel, the add
// tree, rounding and saturation) runs in one pass and lands in the result
// register, while the two-deep input and output histories update at the same
// edge. That feedback through the output history, closed in one pass, sets the rate.
// When the result side stalls, the input register still takes one more
// sample, so the input only stops once both registers are full. Writing
// cutoff_select on the configuration channel picks a coefficient set
// (1 to 6 for cutoff codes 30, 40, 60, 80, 100 and 150) or bypass (0 or 7).
// In bypass each sample passes through unchanged and the history stays as it
// was. Write the register only while no sample is in flight.
module selectable_lowpass_biquad (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration write channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  slpb_pkg::select_t       cfg_data,
    // Input sample channel.
    input  logic                    s_valid,
    output logic                    s_ready,
    input  slpb_pkg::sample_t       s_sample_in,
    // Result channel.
    output logic                    m_valid,
    input  logic                    m_ready,
    output slpb_pkg::sample_t       m_sample_out
);
    import slpb_pkg::*;

    select_t   cutoff_select_reg;
    logic      in_valid_reg;
    sample_t   x_reg;
    sample_t   x_hist0_reg;
    sample_t   x_hist1_reg;
    hist_t     y_hist0_reg;
    hist_t     y_hist1_reg;
    logic      out_valid_reg;
    sample_t   out_sample_reg;

    coef_set_t coefs;
    hist_t     dp_y_hist;
    sample_t   dp_sample;
    logic      advance;
    logic      step;

    // The configuration register can be written in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_select_reg <= SEL_BYPASS;
        end else if (cfg_valid && cfg_ready) begin
            cutoff_select_reg <= cfg_data;
        end
    end

    // The result register can load when it is empty or its transfer completes.
    // The input register can load when it is empty or moves on this cycle.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign step    = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_sample_in;
        end
    end

    slpb_coef_rom u_coef_rom (
        .cutoff_select (cutoff_select_reg),
        .coefs         (coefs)
    );

    slpb_datapath u_datapath (
        .x0       (x_reg),
        .x1       (x_hist0_reg),
        .x2       (x_hist1_reg),
        .y1       (y_hist0_reg),
        .y2       (y_hist1_reg),
        .coefs    (coefs),
        .y_hist   (dp_y_hist),
        .y_sample (dp_sample)
    );

    // Filter history; it moves only when a filtered (not bypassed) sample
    // steps into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_hist0_reg <= '0;
            x_hist1_reg <= '0;
            y_hist0_reg <= '0;
            y_hist1_reg <= '0;
        end else if (step && coefs.active) begin
            x_hist0_reg <= x_reg;
            x_hist1_reg <= x_hist0_reg;
            y_hist0_reg <= dp_y_hist;
            y_hist1_reg <= y_hist0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_sample_reg <= coefs.active ? dp_sample : x_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;

`ifndef NO_ASSERTIONS
    // A bypassed sample leaves the history untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !coefs.active) |=>
            ($stable(x_hist0_reg) && $stable(x_hist1_reg) &&
             $stable(y_hist0_reg) && $stable(y_hist1_reg)))
        else $error("history changed on a bypassed sample");

    // A bypassed sample reaches the result register unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !coefs.active) |=> (m_sample_out == $past(x_reg)))
        else $error("bypass result differs from its input");

    // The input stalls only when both registers hold samples.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // A sample that steps forward always shows up as a valid result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("stepped sample did not produce a result");
`endif

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selectable low-pass biquad. A bit-exact
// fixed-point predictor runs beside the block and checks every output
// sample. Stimulus is a short directed pass over extremes and every cutoff
// code, then random phases of noise, held steps and square waves, with
// random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slpb_pkg::*;

    localparam int      ITEMS       = 1600;
    localparam int      TAIL_ITEMS  = 200;
    localparam int      SETTLE      = 4;
    localparam int      CYCLE_LIMIT = 500000;
    localparam select_t SEL_UNUSED  = 3'd7;
    localparam sample_t SAMPLE_MAX  = sample_t'((2 ** (SAMPLE_WIDTH - 1)) - 1);
    localparam sample_t SAMPLE_MIN  = sample_t'(-(2 ** (SAMPLE_WIDTH - 1)));

    // Predicts the filter output and holds the samples still owed by the block.
    class biquad_scoreboard;
        select_t cutoff;
        longint  x_hist [2];
        longint  y_hist [2];
        sample_t expected_q [$];
        int      errors;

        function new();
            cutoff    = SEL_BYPASS;
            x_hist[0] = 0;
            x_hist[1] = 0;
            y_hist[0] = 0;
            y_hist[1] = 0;
            errors    = 0;
        endfunction

        // Turns a coefficient in units of 1e-4 into Q2.22, rounding half away
        // from zero.
        function longint q22_from_decimal(int d);
            longint mag;
            longint q;
            mag = (d < 0) ? -longint'(d) : longint'(d);
            q   = ((mag << COEF_FRAC_BITS) + 5000) / 10000;
            return (d < 0) ? -q : q;
        endfunction

        function void note_sample(sample_t x);
            int     b_dec;
            int     a0_dec;
            int     a1_dec;
            bit     active;
            longint hist_max;
            longint sum;
            longint acc;
            longint y;
            longint o;
            active = 1'b1;
            b_dec  = 0;
            a0_dec = 0;
            a1_dec = 0;
            case (cutoff)
                SEL_CUT30: begin
                    b_dec = 78;  a0_dec = 17347; a1_dec = -7660;
                end
                SEL_CUT40: begin
                    b_dec = 134; a0_dec = 16457; a1_dec = -7009;
                end
                SEL_CUT60: begin
                    b_dec = 279; a0_dec = 14755; a1_dec = -5869;
                end
                SEL_CUT80: begin
                    b_dec = 461; a0_dec = 13073; a1_dec = -4918;
                end
                SEL_CUT100: begin
                    b_dec = 675; a0_dec = 11430; a1_dec = -4128;
                end
                SEL_CUT150: begin
                    b_dec = 913; a0_dec = 9824;  a1_dec = -3477;
                end
                default: begin
                    active = 1'b0;
                end
            endcase
            // Bypass passes the sample through and leaves the history alone.
            if (!active) begin
                expected_q.push_back(x);
                return;
            end
            hist_max = (longint'(1) << (HIST_WIDTH - 1)) - 1;
            sum = longint'(x) + 2 * x_hist[0] + x_hist[1];
            acc = ((q22_from_decimal(b_dec) * sum) << HIST_FRAC_BITS)
                + q22_from_decimal(a0_dec) * y_hist[0]
                + q22_from_decimal(a1_dec) * y_hist[1]
                + (longint'(1) << (COEF_FRAC_BITS - 1));
            y = acc >>> COEF_FRAC_BITS;
            if (y > hist_max) y = hist_max;
            if (y < -hist_max - 1) y = -hist_max - 1;
            x_hist[1] = x_hist[0];
            x_hist[0] = longint'(x);
            y_hist[1] = y_hist[0];
            y_hist[0] = y;
            // Round to an integer, then saturate a second time at the output.
            o = (y + (longint'(1) << (HIST_FRAC_BITS - 1))) >>> HIST_FRAC_BITS;
            if (o > longint'(SAMPLE_MAX)) o = longint'(SAMPLE_MAX);
            if (o < longint'(SAMPLE_MIN)) o = longint'(SAMPLE_MIN);
            expected_q.push_back(sample_t'(o));
        endfunction

        function void check_result(sample_t got);
            sample_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: sample_out expected none, got %0d", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                $display("%0t: sample_out expected %0d, got %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic    aclk        = 1'b0;
    logic    aresetn     = 1'b0;
    logic    cfg_valid   = 1'b0;
    logic    cfg_ready;
    select_t cfg_data    = SEL_BYPASS;
    logic    s_valid     = 1'b0;
    logic    s_ready;
    sample_t s_sample_in = '0;
    logic    m_valid;
    logic    m_ready     = 1'b0;
    sample_t m_sample_out;

    biquad_scoreboard sb = new();
    int      sent        = 0;
    int      gap_pct     = 0;
    int      stall_pct   = 0;
    longint  cycle_count = 0;

    selectable_lowpass_biquad dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    always #5 aclk = ~aclk;

    // Transfers are observed with the values held just before the edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_sample(s_sample_in);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_sample_out);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("selectable_lowpass_biquad: mismatch");
            $finish;
        end
    end

    // Result side: random stall bursts while stall_pct is nonzero.
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Offers one sample, possibly after an idle burst. Valid stays high after
    // the transfer so back-to-back samples need no second assignment.
    task automatic send_sample(input sample_t x);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // The cutoff register may only change with nothing in flight, so the
    // pipeline is drained first.
    task automatic reconfigure(input select_t sel);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.cutoff = sel;
    endtask

    initial begin
        int      n;
        int      shape;
        int      run;
        int      half;
        int      r;
        bit      tail_phase;
        sample_t level;
        sample_t x;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bypass extremes, every cutoff in turn (each after the first
        // from a nonzero history), and the unused selector code acting as bypass.
        reconfigure(SEL_BYPASS);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(sample_t'(-1));
        for (int c = SEL_CUT30; c <= SEL_CUT150; c++) begin
            reconfigure(select_t'(c));
            send_sample(SAMPLE_MAX);
            send_sample(SAMPLE_MAX);
            send_sample(SAMPLE_MIN);
        end
        reconfigure(SEL_UNUSED);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(16'h5a5a));

        // Random phases, each under one cutoff setting and one idle pattern.
        while (sent < ITEMS) begin
            tail_phase = (sent >= ITEMS - TAIL_ITEMS);
            r = $urandom_range(0, 2);
            gap_pct   = tail_phase ? 0 : (r == 0 ? 0 : (r == 1 ? 5 : 25));
            r = $urandom_range(0, 2);
            stall_pct = tail_phase ? 0 : (r == 0 ? 0 : (r == 1 ? 3 : 15));
            r = $urandom_range(0, 9);
            if (r == 0) begin
                reconfigure(SEL_BYPASS);
            end else if (r == 1) begin
                reconfigure(SEL_UNUSED);
            end else begin
                reconfigure(select_t'($urandom_range(SEL_CUT30, SEL_CUT150)));
            end
            n     = $urandom_range(30, 150);
            shape = $urandom_range(0, 3);
            half  = $urandom_range(1, 40);
            run   = 0;
            level = '0;
            for (int k = 0; k < n; k++) begin
                case (shape)
                    0: x = sample_t'($urandom);
                    1: begin
                        // Held steps, half at the rails and half at random levels, to
                        // drive the overshoot into both saturation stages.
                        if (run == 0) begin
                            r = $urandom_range(0, 3);
                            level = (r == 0) ? SAMPLE_MAX :
                                    (r == 1) ? SAMPLE_MIN : sample_t'($urandom);
                            run = $urandom_range(5, 60);
                        end
                        x = level;
                        run--;
                    end
                    2: x = sample_t'($urandom_range(0, 64) - 32);
                    default: x = ((k / half) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
                endcase
                send_sample(x);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("selectable_lowpass_biquad: match");
        end else begin
            $display("selectable_lowpass_biquad: mismatch");
        end
        $finish;
    end

endmodule
